/* sv/spdif_subframe_biphase_encoder_core_defines.svh */
// ---------------------------------------------------------------------------
// S/PDIF subframe encoder assertion macros
// Shared property wrappers for the encoder's checker.
// ---------------------------------------------------------------------------
`ifndef SPDIF_SUBFRAME_BIPHASE_ENCODER_CORE_DEFINES_SVH
`define SPDIF_SUBFRAME_BIPHASE_ENCODER_CORE_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define SPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Property checked on every rising edge, reset included.
`define SPD_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/spdbme_pkg.sv */
// ---------------------------------------------------------------------------
// S/PDIF subframe encoder package
// Shared types, register indices, preamble patterns and the biphase coder.
// ---------------------------------------------------------------------------
package spdbme_pkg;

	// Configuration register indices.
	localparam logic [1:0] REG_VOLUME       = 2'd0;
	localparam logic [1:0] REG_LEFT_ENABLE  = 2'd1;
	localparam logic [1:0] REG_RIGHT_ENABLE = 2'd2;
	localparam logic [1:0] REG_BYTE_SWAP    = 2'd3;

	// Preamble wire patterns, before polarity adjustment.
	localparam logic [15:0] PRE_X = 16'hE2CC;
	localparam logic [15:0] PRE_Y = 16'hE4CC;
	localparam logic [15:0] PRE_Z = 16'hE8CC;

	// Position of the subframe within its block.
	typedef struct packed {
		logic is_first;
		logic is_right;
	} sf_ctl_t;

	// Subframe bytes 1 to 3 (byte 0 is always zero and is carried by the preamble).
	typedef struct packed {
		logic [7:0] byte3;
		logic [7:0] byte2;
		logic [7:0] byte1;
	} sf_bytes_t;

	// Biphase-mark code of one byte, LSB first, starting at level 1.
	function automatic logic [15:0] biphase(input logic [7:0] b);
		logic        lvl;
		logic        sec;
		logic [15:0] w;
		lvl = 1'b1;
		w   = '0;
		for (int k = 0; k < 8; k++) begin
			sec = lvl ^ b[k];
			w   = {w[13:0], lvl, sec};
			lvl = ~sec;
		end
		return w;
	endfunction

endpackage

/* sv/spdbme_scale.sv */
// ---------------------------------------------------------------------------
// S/PDIF subframe encoder sample scaler
// Assembles the PCM sample, applies the channel gain and forms the data bytes
// of the subframe together with the even parity bit.
// ---------------------------------------------------------------------------
module spdbme_scale (
	input  logic [7:0]          first_byte,
	input  logic [7:0]          second_byte,
	input  logic                silent,
	input  logic [15:0]         volume_word,
	input  logic                left_enable,
	input  logic                right_enable,
	input  logic                byte_swap,
	input  spdbme_pkg::sf_ctl_t ctl,
	output spdbme_pkg::sf_bytes_t bytes
);
	import spdbme_pkg::*;

	logic signed [15:0] sample;
	logic [8:0]         vol_sum;
	logic [5:0]         gain;
	logic               chan_en;
	logic signed [22:0] prod;
	logic [23:0]        prod_ext;
	logic               parity;

	// Sample assembly from the two stored bytes.
	assign sample = byte_swap ? $signed({first_byte, second_byte})
	                          : $signed({second_byte, first_byte});

	// Gain is the average of the two volume bytes divided by four.
	assign vol_sum = {1'b0, volume_word[15:8]} + {1'b0, volume_word[7:0]};
	assign chan_en = ctl.is_right ? right_enable : left_enable;
	assign gain    = chan_en ? vol_sum[8:3] : 6'd0;

	// Signed product, sign-extended to the 24 bits of the audio field.
	assign prod     = sample * $signed({1'b0, gain});
	assign prod_ext = {prod[22], prod};
	assign parity   = ^prod_ext[23:4];

	// Subframe bytes; silence gives a zero sample with zero parity.
	always_comb begin
		if (silent) begin
			bytes = '0;
		end else begin
			bytes.byte1 = prod_ext[11:4];
			bytes.byte2 = prod_ext[19:12];
			bytes.byte3 = {parity, 3'b000, prod_ext[23:20]};
		end
	end

endmodule

/* sv/spdbme_wire.sv */
// ---------------------------------------------------------------------------
// S/PDIF subframe encoder line coder
// Selects the preamble, codes the data bytes in biphase mark and keeps the
// line level continuous from word to word.
// ---------------------------------------------------------------------------
module spdbme_wire (
	input  spdbme_pkg::sf_ctl_t   ctl,
	input  spdbme_pkg::sf_bytes_t bytes,
	input  logic                  polarity,
	output logic [15:0]           wire_word0,
	output logic [15:0]           wire_word1,
	output logic [15:0]           wire_word2,
	output logic [15:0]           wire_word3,
	output logic                  polarity_next
);
	import spdbme_pkg::*;

	logic [15:0] pre;

	// Z opens a block, Y marks the right channel, X the left.
	always_comb begin
		if (ctl.is_first) begin
			pre = PRE_Z;
		end else if (ctl.is_right) begin
			pre = PRE_Y;
		end else begin
			pre = PRE_X;
		end
	end

	// Each word is inverted when the previous wire bit was high.
	assign wire_word0    = pre ^ {16{polarity}};
	assign wire_word1    = biphase(bytes.byte1) ^ {16{wire_word0[0]}};
	assign wire_word2    = biphase(bytes.byte2) ^ {16{wire_word1[0]}};
	assign wire_word3    = biphase(bytes.byte3) ^ {16{wire_word2[0]}};
	assign polarity_next = wire_word3[0];

endmodule

/* sv/spdif_subframe_biphase_encoder_core.sv */
// Path: the scaler and line coder sit between the input register and the result
// register, which holds the wire words of a sample until they are taken.
// Throughput: one sample per cycle while the result register is not stalled. The
// subframe count and line level advance as each sample enters the result register.
// Reset: arst_n clears both valid bits, the count and the line level, and sets the
// configuration registers to their defaults; the data registers are not reset.
// ---------------------------------------------------------------------------
// S/PDIF subframe biphase-mark encoder
// Turns PCM samples into preambled, biphase-coded subframes of four words.
// ---------------------------------------------------------------------------
module spdif_subframe_biphase_encoder_core #(
	parameter int SUBFRAMES_PER_BLOCK = 384
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Sample channel.
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [7:0]  first_byte,
	input  logic [7:0]  second_byte,
	input  logic        silent,
	// Wire word channel.
	output logic        word_valid,
	input  logic        word_stall,
	output logic [15:0] wire_word0,
	output logic [15:0] wire_word1,
	output logic [15:0] wire_word2,
	output logic [15:0] wire_word3
);
	import spdbme_pkg::*;

	localparam int CntW = $clog2(SUBFRAMES_PER_BLOCK);
	localparam logic [CntW-1:0] CntLast = CntW'(SUBFRAMES_PER_BLOCK - 1);

	logic [15:0]     volume_q;
	logic            left_en_q;
	logic            right_en_q;
	logic            swap_q;
	logic [CntW-1:0] count_q;
	logic            polarity_q;

	logic            valid_s1;
	logic [7:0]      first_byte_s1;
	logic [7:0]      second_byte_s1;
	logic            silent_s1;

	logic            word_valid_q;
	logic [15:0]     word0_q;
	logic [15:0]     word1_q;
	logic [15:0]     word2_q;
	logic [15:0]     word3_q;

	logic            advance;
	sf_ctl_t         ctl;
	sf_bytes_t       bytes;
	logic [15:0]     w0;
	logic [15:0]     w1;
	logic [15:0]     w2;
	logic [15:0]     w3;
	logic            polarity_next;

	// Configuration registers accept a write on every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q   <= 16'hFFFF;
			left_en_q  <= 1'b1;
			right_en_q <= 1'b1;
			swap_q     <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VOLUME:       volume_q   <= cfg_data;
				REG_LEFT_ENABLE:  left_en_q  <= cfg_data[0];
				REG_RIGHT_ENABLE: right_en_q <= cfg_data[0];
				REG_BYTE_SWAP:    swap_q     <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// The input stage moves on when the result register is free or being emptied.
	assign advance      = !word_valid_q || !word_stall;
	assign sample_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			first_byte_s1  <= first_byte;
			second_byte_s1 <= second_byte;
			silent_s1      <= silent;
		end
	end

	// Block position of the sample in the input register.
	assign ctl.is_first = (count_q == '0);
	assign ctl.is_right = count_q[0];

	spdbme_scale u_scale (
		.first_byte   (first_byte_s1),
		.second_byte  (second_byte_s1),
		.silent       (silent_s1),
		.volume_word  (volume_q),
		.left_enable  (left_en_q),
		.right_enable (right_en_q),
		.byte_swap    (swap_q),
		.ctl          (ctl),
		.bytes        (bytes)
	);

	spdbme_wire u_wire (
		.ctl           (ctl),
		.bytes         (bytes),
		.polarity      (polarity_q),
		.wire_word0    (w0),
		.wire_word1    (w1),
		.wire_word2    (w2),
		.wire_word3    (w3),
		.polarity_next (polarity_next)
	);

	// Subframe count and line level advance with each transfer into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			polarity_q   <= 1'b0;
			word_valid_q <= 1'b0;
		end else if (advance) begin
			word_valid_q <= valid_s1;
			if (valid_s1) begin
				polarity_q <= polarity_next;
				count_q    <= (count_q == CntLast) ? '0 : count_q + 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			word0_q <= w0;
			word1_q <= w1;
			word2_q <= w2;
			word3_q <= w3;
		end
	end

	assign word_valid = word_valid_q;
	assign wire_word0 = word0_q;
	assign wire_word1 = word1_q;
	assign wire_word2 = word2_q;
	assign wire_word3 = word3_q;

endmodule

/* sv/spdbme_chk.sv */
// ---------------------------------------------------------------------------
// S/PDIF subframe encoder port checker
// Watches the top-level ports for reset, handshake and line continuity faults.
// ---------------------------------------------------------------------------
`include "spdif_subframe_biphase_encoder_core_defines.svh"

module spdbme_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_valid,
	input logic        sample_stall,
	input logic        word_valid,
	input logic        word_stall,
	input logic [15:0] wire_word0,
	input logic [15:0] wire_word1,
	input logic [15:0] wire_word2,
	input logic [15:0] wire_word3
);

	logic in_xfer;
	logic line_ok;

	// A sample transfer at this edge.
	assign in_xfer = sample_valid && !sample_stall;

	// Each data word opens with a transition from the last bit of the word before it.
	assign line_ok = (wire_word1[15] != wire_word0[0]) && (wire_word2[15] != wire_word1[0])
	                 && (wire_word3[15] != wire_word2[0]);

	// No result is offered while reset is held.
	`SPD_ASSERT_RST(a_reset_idle, (!arst_n |-> !word_valid), "result offered during reset")

	// A stalled result stays on offer.
	`SPD_ASSERT(a_hold, (word_valid && word_stall |=> word_valid), "stalled result withdrawn")

	// Every new result follows a sample transfer that passed through the input register.
	`SPD_ASSERT(a_origin, ($rose(word_valid) |-> $past(in_xfer, 2)), "result without a sample")

	// The line level stays continuous across the words of a result.
	`SPD_ASSERT(a_continuity, (word_valid |-> line_ok), "line level discontinuity")

endmodule

bind spdif_subframe_biphase_encoder_core spdbme_chk u_spdbme_chk (.*);
